/* sv/rrbc_pkg.sv */
// Shared types and constants for the ROM/RAM bus controller with stack guard.
// Used by rrbc_ctrl, rrbc_dp and the top level; no dependencies.
`timescale 1ns / 1ps

package rrbc_pkg;

  // Memory map and stack geometry
  localparam int unsigned ROM_BYTES   = 4096;
  localparam int unsigned RAM_BYTES   = 4096;
  localparam int unsigned STACK_BYTES = 1024;

  localparam logic [31:0] ROM_BASE    = 32'h0000_0000;
  localparam logic [31:0] RAM_BASE    = 32'h2000_0000;
  localparam logic [31:0] RAM_TOP     = RAM_BASE + 32'(RAM_BYTES) - 32'd1;
  localparam logic [31:0] SP_FLOOR    = RAM_TOP - 32'(STACK_BYTES);

  localparam int unsigned ROM_AW = $clog2(ROM_BYTES);
  localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

  // Clear sweep covers the larger of the two arrays
  localparam int unsigned CLR_DEPTH = (ROM_BYTES > RAM_BYTES) ? ROM_BYTES : RAM_BYTES;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_PUSH  = 3'd2,
    OP_POP   = 3'd3,
    OP_PROG  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_ROMWR = 3'd1,
    STS_BUS   = 3'd2,
    STS_OVF   = 3'd3,
    STS_UNF   = 3'd4
  } status_t;

  // Source of the returned byte
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_FF   = 2'd1,
    SEL_ROM  = 2'd2,
    SEL_RAM  = 2'd3
  } sel_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2,
    S_RESP  = 2'd3
  } state_t;

  typedef struct packed {
    logic latch_req;  // capture the incoming request
    logic exec;       // decode, access memory, update stack pointer
    logic clr_en;     // memory clear sweep active
    logic load_out;   // move result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;   // last entry of the clear sweep is being written
  } dp_stat_t;

endpackage

/* sv/rrbc_ctrl.sv */
// Controller FSM: clear sweep, request accept, execute and result hand-off.
// Depends on rrbc_pkg.
`timescale 1ns / 1ps

module rrbc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  rrbc_pkg::dp_stat_t   stat,
  output rrbc_pkg::ctrl_cmd_t  cmd
);
  import rrbc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.latch_req = in_tvalid;
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

/* sv/rrbc_dp.sv */
// Datapath: request latch, address decode, ROM/RAM arrays, stack pointer,
// clear counter and output register. Depends on rrbc_pkg.
`timescale 1ns / 1ps

module rrbc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rrbc_pkg::ctrl_cmd_t                  cmd,
  output rrbc_pkg::dp_stat_t                   stat,
  input  logic [rrbc_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic [rrbc_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import rrbc_pkg::*;

  // Request latch
  op_t         req_op_r;
  logic [31:0] req_addr_r;
  logic [7:0]  req_data_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_op_r   <= op_t'(in_tdata[2:0]);
      req_addr_r <= in_tdata[34:3];
      req_data_r <= in_tdata[42:35];
    end
  end

  // Clear sweep counter
  logic [CLR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + CLR_W'(1);
  end

  assign stat.clr_done = (clr_cnt_r == CLR_W'(CLR_DEPTH - 1));

  // Stack pointer and decode
  logic [31:0] sp_r, sp_nxt;
  logic [31:0] sp_inc, ea, ram_off;
  logic        ovf, unf, ea_rom, ea_ram;
  logic        rom_we_op, ram_we_op, sp_upd;
  status_t     sts;
  sel_t        sel;

  assign ovf     = (sp_r <= SP_FLOOR);
  assign unf     = (sp_r >= RAM_TOP);
  assign sp_inc  = sp_r + 32'd1;

  always_comb begin
    case (req_op_r)
      OP_PUSH: ea = sp_r;
      OP_POP:  ea = sp_inc;
      default: ea = req_addr_r;
    endcase
  end

  assign ram_off = ea - RAM_BASE;
  assign ea_rom  = ((ea - ROM_BASE) < 32'(ROM_BYTES));
  assign ea_ram  = (ea >= RAM_BASE) && (ram_off < 32'(RAM_BYTES));

  always_comb begin
    sts       = STS_OK;
    sel       = SEL_ZERO;
    rom_we_op = 1'b0;
    ram_we_op = 1'b0;
    sp_upd    = 1'b0;
    sp_nxt    = sp_r;
    case (req_op_r)
      OP_READ, OP_POP: begin
        if (req_op_r == OP_POP && unf) begin
          sts = STS_UNF;
        end else begin
          if (req_op_r == OP_POP) begin
            sp_upd = 1'b1;
            sp_nxt = sp_inc;
          end
          if (ea_rom) sel = SEL_ROM;
          else if (ea_ram) sel = SEL_RAM;
          else begin
            sel = SEL_FF;
            sts = STS_BUS;
          end
        end
      end
      OP_WRITE, OP_PUSH: begin
        if (req_op_r == OP_PUSH && ovf) begin
          sts = STS_OVF;
        end else begin
          if (req_op_r == OP_PUSH) begin
            sp_upd = 1'b1;
            sp_nxt = sp_r - 32'd1;
          end
          if (ea_rom) sts = STS_ROMWR;
          else if (ea_ram) ram_we_op = 1'b1;
          else sts = STS_BUS;
        end
      end
      OP_PROG: begin
        if (ea_rom) rom_we_op = 1'b1;
        else sts = STS_BUS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sp_r <= RAM_TOP;
    else if (cmd.exec && sp_upd) sp_r <= sp_nxt;
  end

  status_t sts_r;
  sel_t    sel_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sts_r <= sts;
      sel_r <= sel;
    end
  end

  // Memory arrays: one write and one registered read per cycle each
  logic [7:0] rom_mem [ROM_BYTES];
  logic [7:0] ram_mem [RAM_BYTES];
  logic [7:0] rom_q_r, ram_q_r;

  logic              rom_we, ram_we;
  logic [ROM_AW-1:0] rom_idx, rom_widx;
  logic [RAM_AW-1:0] ram_idx, ram_widx;
  logic [7:0]        rom_wdata, ram_wdata;

  assign rom_idx = ea[ROM_AW-1:0];
  assign ram_idx = ram_off[RAM_AW-1:0];

  always_comb begin
    if (cmd.clr_en) begin
      rom_we    = ({1'b0, clr_cnt_r} < (CLR_W+1)'(ROM_BYTES));
      ram_we    = ({1'b0, clr_cnt_r} < (CLR_W+1)'(RAM_BYTES));
      rom_widx  = clr_cnt_r[ROM_AW-1:0];
      ram_widx  = clr_cnt_r[RAM_AW-1:0];
      rom_wdata = 8'hFF;
      ram_wdata = 8'h00;
    end else begin
      rom_we    = cmd.exec && rom_we_op;
      ram_we    = cmd.exec && ram_we_op;
      rom_widx  = rom_idx;
      ram_widx  = ram_idx;
      rom_wdata = req_data_r;
      ram_wdata = req_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) rom_mem[rom_widx] <= rom_wdata;
    if (cmd.exec) rom_q_r <= rom_mem[rom_idx];
  end

  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_widx] <= ram_wdata;
    if (cmd.exec) ram_q_r <= ram_mem[ram_idx];
  end

  // Output register
  logic [7:0] rd_byte;
  logic [7:0] out_rd_r;
  status_t    out_sts_r;
  logic [31:0] out_sp_r;

  always_comb begin
    case (sel_r)
      SEL_FF:  rd_byte = 8'hFF;
      SEL_ROM: rd_byte = rom_q_r;
      SEL_RAM: rd_byte = ram_q_r;
      default: rd_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rd_r  <= rd_byte;
      out_sts_r <= sts_r;
      out_sp_r  <= sp_r;
    end
  end

  assign out_tdata = {5'd0, out_sp_r, out_sts_r, out_rd_r};

endmodule

/* sv/rom_ram_bus_controller_with_stack_guard.sv */
// ROM/RAM bus controller with stack guard: top level.
// Each request passes the states accept, execute (decode and memory access)
// and result load; the result is then shown on out_tvalid and may wait there
// while the next request enters; a new request is taken only after that load.
// Reset: synchronous active-low rst_n; afterwards a clear sweep over 4096 entries
// (the larger of ROM_BYTES and RAM_BYTES) fills ROM with 0xFF and RAM with 0,
// in_tready stays low during the sweep. Depends on rrbc_pkg, rrbc_ctrl, rrbc_dp.
`timescale 1ns / 1ps

module rom_ram_bus_controller_with_stack_guard (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] opcode, [34:3] address, [42:35] data, [47:43] zero
  input  logic [rrbc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] read_data, [10:8] status, [42:11] stack_pointer_now, [47:43] zero
  output logic [rrbc_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import rrbc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencing: clear sweep, then accept / execute / respond per request
  rrbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Decode, memories, stack pointer and output register
  rrbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

  // No request taken while memories are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !in_tready)
    else $error("request accepted during clear sweep");

  // An accepted request is executed in the very next cycle
  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.exec)
    else $error("accepted request not executed");

  // Only one request in flight: no accept while executing
  a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !in_tready)
    else $error("request accepted during execute");

  // A loaded result is presented on the next cycle
  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("result loaded but not presented");

endmodule
